/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bvps_pkg.sv */
// Package for the bitmap with population count: sizes, opcodes,
// controller/datapath command and status structs, and the byte popcount.
// No dependencies.
package bvps_pkg;

    localparam int MAX_BITS    = 4095;
    localparam int STORE_BYTES = 512;
    localparam int SIZE_W      = 12;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int IDX_W       = $clog2(STORE_BYTES + 1);
    localparam int CNT_W       = 13;
    localparam int COUNT_MAX   = 8191;
    localparam int SUM_RAW_W   = $clog2(STORE_BYTES * BYTE_W + 1);
    localparam int SUM_W       = (SUM_RAW_W > CNT_W) ? SUM_RAW_W : CNT_W;
    localparam int RESET_SIZE  = (MAX_BITS < 4095) ? MAX_BITS : 4095;
    localparam int RESET_BYTES = ((RESET_SIZE >> 3) + 1 > STORE_BYTES) ?
                                 STORE_BYTES : (RESET_SIZE >> 3) + 1;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_AND    = 3'd2,
        OP_OR     = 3'd3,
        OP_GET    = 3'd4,
        OP_INVERT = 3'd5,
        OP_COUNT  = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    typedef struct packed {
        logic accept;      // latch the incoming item and read its byte
        logic exec;        // finish an item that needs no walk and load the result
        logic walk_start;  // restart the store walk
        logic walk;        // one step of the store walk
        logic finish;      // load the result of a walk
        logic clear;       // one step of the clearing pass
    } t_cmd;

    typedef struct packed {
        logic need_walk;   // latched item must walk the whole store
        logic walk_done;   // all bytes read and processed
        logic clear_last;  // clearing pass writes its last entry
    } t_stat;

    function automatic logic [3:0] byte_pop(input logic [BYTE_W-1:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/bvps_datapath.sv */
// Datapath of the bitmap: byte store memory, item registers, walk counter,
// popcount accumulator, count cache and result registers.
// Depends on bvps_pkg.
module bvps_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bvps_pkg::t_cmd              i_cmd,
    output bvps_pkg::t_stat             o_stat,
    input  logic                        i_cfg_we,
    input  logic [bvps_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic [2:0]                  i_opcode,
    input  logic [bvps_pkg::SIZE_W-1:0] i_bit_index,
    input  logic                        i_other_value,
    output logic                        o_bit_value,
    output logic [bvps_pkg::CNT_W-1:0]  o_set_count,
    output logic                        o_index_error
);

    logic [bvps_pkg::BYTE_W-1:0] r_mem [bvps_pkg::STORE_BYTES];
    logic [bvps_pkg::BYTE_W-1:0] r_rd_data;
    bvps_pkg::t_op               r_op;
    logic [bvps_pkg::SIZE_W-1:0] r_bit_index;
    logic                        r_other;
    logic [bvps_pkg::IDX_W-1:0]  r_idx;
    logic [bvps_pkg::ADDR_W-1:0] r_wr_addr;
    logic                        r_pend;
    logic [bvps_pkg::SUM_W-1:0]  r_sum;
    logic [bvps_pkg::CNT_W-1:0]  r_cache;
    logic                        r_cache_valid;
    logic [bvps_pkg::IDX_W-1:0]  r_nbytes;
    logic [bvps_pkg::IDX_W-1:0]  n_nbytes;
    logic                        r_bit_value;
    logic [bvps_pkg::CNT_W-1:0]  r_set_count;
    logic                        r_index_error;

    logic [bvps_pkg::SIZE_W-4:0] byte_sel;
    logic [2:0]                  pos;
    logic [bvps_pkg::BYTE_W-1:0] mask;
    logic [bvps_pkg::BYTE_W-1:0] new_byte;
    logic                        err;
    logic                        idx_in_range;
    logic                        rd_go;
    logic                        wr_single;
    logic                        rd_en;
    logic [bvps_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_en;
    logic [bvps_pkg::ADDR_W-1:0] wr_addr;
    logic [bvps_pkg::BYTE_W-1:0] wr_data;
    logic [bvps_pkg::CNT_W-1:0]  sat_sum;
    int unsigned                 cfg_size;
    int unsigned                 cfg_bytes;

    // Stored byte count follows the size register, capped to the store.
    always_comb begin
        cfg_size = int'(i_cfg_data);
        if (cfg_size > bvps_pkg::MAX_BITS) begin
            cfg_size = bvps_pkg::MAX_BITS;
        end
        cfg_bytes = (cfg_size >> 3) + 1;
        if (cfg_bytes > bvps_pkg::STORE_BYTES) begin
            cfg_bytes = bvps_pkg::STORE_BYTES;
        end
        n_nbytes = bvps_pkg::IDX_W'(cfg_bytes);
    end

    always_comb begin
        byte_sel     = r_bit_index[bvps_pkg::SIZE_W-1:3];
        pos          = r_bit_index[2:0];
        mask         = bvps_pkg::BYTE_W'(1) << pos;
        err          = (r_op <= bvps_pkg::OP_GET) && (int'(byte_sel) >= int'(r_nbytes));
        idx_in_range = r_idx < r_nbytes;
        rd_go        = i_cmd.walk && idx_in_range;
        wr_single    = i_cmd.exec && !err && (r_op <= bvps_pkg::OP_OR);
        case (r_op)
            bvps_pkg::OP_SET:   new_byte = r_rd_data | mask;
            bvps_pkg::OP_CLEAR: new_byte = r_rd_data & ~mask;
            bvps_pkg::OP_AND:   new_byte = r_other ? r_rd_data : (r_rd_data & ~mask);
            bvps_pkg::OP_OR:    new_byte = r_other ? (r_rd_data | mask) : r_rd_data;
            default:            new_byte = r_rd_data;
        endcase
        if (r_sum > bvps_pkg::SUM_W'(bvps_pkg::COUNT_MAX)) begin
            sat_sum = bvps_pkg::CNT_W'(bvps_pkg::COUNT_MAX);
        end else begin
            sat_sum = r_sum[bvps_pkg::CNT_W-1:0];
        end
    end

    // One read port and one write port on the store.
    always_comb begin
        rd_en   = i_cmd.accept || rd_go;
        rd_addr = i_cmd.accept ? bvps_pkg::ADDR_W'(i_bit_index[bvps_pkg::SIZE_W-1:3])
                               : r_idx[bvps_pkg::ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[bvps_pkg::ADDR_W-1:0];
        wr_data = '0;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (wr_single) begin
            wr_en   = 1'b1;
            wr_addr = bvps_pkg::ADDR_W'(byte_sel);
            wr_data = new_byte;
        end else if (i_cmd.walk && r_pend && (r_op == bvps_pkg::OP_INVERT)) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_addr;
            wr_data = ~r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_pend        <= 1'b0;
            r_cache_valid <= 1'b0;
            r_nbytes      <= bvps_pkg::IDX_W'(bvps_pkg::RESET_BYTES);
        end else begin
            if (i_cfg_we) begin
                r_nbytes <= n_nbytes;
            end
            if (i_cfg_we || i_cmd.walk_start) begin
                r_idx <= '0;
            end else if (i_cmd.clear || rd_go) begin
                r_idx <= r_idx + bvps_pkg::IDX_W'(1);
            end
            if (i_cmd.walk_start) begin
                r_pend <= 1'b0;
            end else if (i_cmd.walk) begin
                r_pend <= rd_go;
            end
            if (i_cfg_we || wr_single ||
                (i_cmd.walk_start && (r_op == bvps_pkg::OP_INVERT))) begin
                r_cache_valid <= 1'b0;
            end else if (i_cmd.finish && (r_op == bvps_pkg::OP_COUNT)) begin
                r_cache_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= bvps_pkg::t_op'(i_opcode);
            r_bit_index <= i_bit_index;
            r_other     <= i_other_value;
        end
        if (rd_go) begin
            r_wr_addr <= r_idx[bvps_pkg::ADDR_W-1:0];
        end
        if (i_cmd.walk_start) begin
            r_sum <= '0;
        end else if (i_cmd.walk && r_pend && (r_op == bvps_pkg::OP_COUNT)) begin
            r_sum <= r_sum + bvps_pkg::SUM_W'(bvps_pkg::byte_pop(r_rd_data));
        end
        if (i_cmd.finish && (r_op == bvps_pkg::OP_COUNT)) begin
            r_cache <= sat_sum;
        end
        if (i_cmd.exec) begin
            r_bit_value   <= (r_op == bvps_pkg::OP_GET) && !err && r_rd_data[pos];
            r_set_count   <= (r_op == bvps_pkg::OP_COUNT) ? r_cache : '0;
            r_index_error <= err;
        end else if (i_cmd.finish) begin
            r_bit_value   <= 1'b0;
            r_set_count   <= (r_op == bvps_pkg::OP_COUNT) ? sat_sum : '0;
            r_index_error <= 1'b0;
        end
    end

    always_comb begin
        o_stat.need_walk  = (r_op == bvps_pkg::OP_INVERT) ||
                            ((r_op == bvps_pkg::OP_COUNT) && !r_cache_valid);
        o_stat.walk_done  = !idx_in_range && !r_pend;
        o_stat.clear_last = r_idx == bvps_pkg::IDX_W'(bvps_pkg::STORE_BYTES - 1);
    end

    assign o_bit_value   = r_bit_value;
    assign o_set_count   = r_set_count;
    assign o_index_error = r_index_error;

endmodule

/* hw/rtl/bvps_ctrl.sv */
// Controller of the bitmap: state machine over clearing, idle, single-byte
// execution, store walk and walk result; owns the result valid flag.
// Depends on bvps_pkg.
module bvps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  logic            i_cfg_we,
    input  bvps_pkg::t_stat i_stat,
    output bvps_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_OP    = 5'b00100,
        S_WALK  = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && !i_cfg_we) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_OP;
                end
            end
            S_OP: begin
                if (i_stat.need_walk) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end else if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // A size write empties the store: restart the clearing pass.
        if (i_cfg_we) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.exec || o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/bit_vector_popcount_store.sv */
// Bitmap with population count. The block holds a bitmap of up to 4096 bits in a
// 512-byte single-port-read, single-port-write memory; the number of stored bytes
// is (size_in_bits >> 3) + 1. Each input transfer carries an opcode: set, clear,
// and-bit, or-bit and get work on the one byte that holds bit_index, invert-all
// flips every stored byte (padding bits above size_in_bits included), and count
// returns the number of ones over every stored byte. Every input transfer yields
// exactly one output transfer. A bit index whose byte lies beyond the stored bytes
// is not applied and comes back with index_error set. A single-bit operation or
// get reads its byte as the input is taken, then (but for get) writes it back
// modified and loads the result once the output register is free; count takes
// this path too when the last count is still cached, since any change to the
// bitmap drops the cache. Invert-all and an uncached count walk the memory one
// byte per cycle through its read port, then load the result likewise. After
// reset, and after every write of size_in_bits, the block clears all 512 bytes
// in a clearing pass, holding o_stall high; a size write empties the bitmap. The
// result sits in an output register, so the next item is taken while a finished
// result still waits for the downstream side. The user writes size_in_bits over
// the configuration channel only while the block is idle; the block won't check.
// Depends on bvps_pkg, bvps_ctrl and bvps_datapath.
module bit_vector_popcount_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item input channel.
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_opcode,
    input  logic [bvps_pkg::SIZE_W-1:0] i_bit_index,
    input  logic                        i_other_value,
    // Result output channel.
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_bit_value,
    output logic [bvps_pkg::CNT_W-1:0]  o_set_count,
    output logic                        o_index_error,
    // Configuration write channel for size_in_bits.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bvps_pkg::SIZE_W-1:0] i_cfg_data
);

    bvps_pkg::t_cmd  cmd;
    bvps_pkg::t_stat stat;
    logic            cfg_we;

    // The size register is always writable; a write restarts the clearing pass.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    bvps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_cfg_we    (cfg_we),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    // The datapath applies each command: memory access, walk step, result load.
    bvps_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_bit_index   (i_bit_index),
        .i_other_value (i_other_value),
        .o_bit_value   (o_bit_value),
        .o_set_count   (o_set_count),
        .o_index_error (o_index_error)
    );

endmodule

/* hw/rtl/bvps_checker.sv */
// Port-level checker for the bitmap block, attached to the top level by bind.
// Depends on bvps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bvps_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_bit_value,
    input logic [bvps_pkg::CNT_W-1:0] o_set_count,
    input logic                       o_index_error,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready
);

    // The clearing pass runs right after reset, so no item is taken then.
    `ASSERT_IMPLIES(a_stall_after_reset, i_clk, i_rst_n, !$past(i_rst_n), o_stall, "item taken during clearing pass after reset")
    // One item at a time: the cycle after an input transfer is always stalled.
    `ASSERT_NEXT(a_stall_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "second item taken while one is in work")
    // A size write starts a clearing pass.
    `ASSERT_NEXT(a_stall_after_cfg, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, o_stall, "no clearing pass after size write")
    // A pending result stays offered until it is taken.
    `ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")
    // A rejected index returns no bit and no count.
    `ASSERT_IMPLIES(a_error_fields, i_clk, i_rst_n, o_valid && o_index_error, !o_bit_value && (o_set_count == 0), "index error with nonzero data")

endmodule

bind bit_vector_popcount_store bvps_checker u_bvps_checker (.*);
